>>> rtl/aabb_xf_pkg.sv
// ----------------------------------------------------------------------------
// aabb_xf_pkg
// Shared types, constants and helper functions of the bounding-box affine
// transform: fixed-point widths, register map and field extraction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aabb_xf_pkg;

    // Geometry
    localparam int NUM_AXES  = 3;

    // Fixed-point formats: Q4.12 coefficients, Q10.6 coordinates
    localparam int COORD_W   = 16;
    localparam int COEF_W    = 16;
    localparam int FRAC_BITS = 12;
    localparam int PROD_W    = COORD_W + COEF_W;        // Q.18 product
    localparam int SUM_W     = PROD_W + 2;              // three products summed
    localparam int SHIFT_W   = SUM_W - FRAC_BITS;       // after the floor shift
    localparam int ACC_W     = SHIFT_W + 1;             // plus translation

    // Stream payload
    localparam int TDATA_W   = 2 * NUM_AXES * COORD_W;

    // Configuration port
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic [CFG_DATA_W-1:0]     row_t;
    typedef logic [1:0]                reg_idx_t;

    // Register indexes (byte address = 8 * index)
    localparam reg_idx_t REG_ROW_X = 2'd0;
    localparam reg_idx_t REG_ROW_Y = 2'd1;
    localparam reg_idx_t REG_ROW_Z = 2'd2;

    // Identity transform after reset
    localparam row_t ROW_X_RESET = 64'h1000_0000_0000_0000;
    localparam row_t ROW_Y_RESET = 64'h0000_1000_0000_0000;
    localparam row_t ROW_Z_RESET = 64'h0000_0000_1000_0000;

    // Coefficient k of a row: k = 0 sits in the top 16 bits
    function automatic coord_t coef_of(input row_t row, input int k);
        coef_of = row[CFG_DATA_W - COEF_W - COEF_W*k +: COEF_W];
    endfunction

    // Translation sits in the lowest 16 bits
    function automatic coord_t trans_of(input row_t row);
        trans_of = row[COORD_W-1:0];
    endfunction

    // Clamp to the signed 16-bit range
    function automatic coord_t sat_coord(input acc_t v);
        if (v > acc_t'(32767)) begin
            sat_coord = 16'sh7FFF;
        end else if (v < -acc_t'(32768)) begin
            sat_coord = 16'sh8000;
        end else begin
            sat_coord = v[COORD_W-1:0];
        end
    endfunction

endpackage

>>> rtl/aabb_affine_transform_top.sv
// ----------------------------------------------------------------------------
// aabb_affine_transform_top
// Maps an axis-aligned box through a configured affine transform and returns
// the axis-aligned box bounding its eight transformed corners.
//
// The block takes one box per clock cycle while the result side accepts and
// returns the results in order, each passing through the four register
// stages (products, per-term min/max, three-term sums, shift, translate and
// saturate). Because every output axis is a sum of independent terms passed
// through monotonic rounding and clamping, the bound of the eight corners is
// the sum of the per-term minima (or maxima), so no corner is formed
// explicitly. A stall on the result side holds full stages; s_tready drops
// only once all stages are full. An input with child_valid low gives a result
// with box_valid low and all coordinates zero. The three transform rows are
// 64-bit registers at byte addresses 0x00, 0x08 and 0x10 and may only be
// written while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabb_affine_transform_top (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Input box stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z
    input  logic [aabb_xf_pkg::TDATA_W-1:0]     s_tdata,
    // child_valid
    input  logic [0:0]                          s_tuser,

    // Result box stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
    output logic [aabb_xf_pkg::TDATA_W-1:0]     m_tdata,
    // box_valid
    output logic [0:0]                          m_tuser,

    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [aabb_xf_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [aabb_xf_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [aabb_xf_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                pready
);

    localparam int NA = aabb_xf_pkg::NUM_AXES;
    localparam int CW = aabb_xf_pkg::COORD_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    aabb_xf_pkg::row_t     row_reg [NA];
    aabb_xf_pkg::reg_idx_t cfg_idx;
    logic                  cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:3];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0] <= aabb_xf_pkg::ROW_X_RESET;
            row_reg[1] <= aabb_xf_pkg::ROW_Y_RESET;
            row_reg[2] <= aabb_xf_pkg::ROW_Z_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                aabb_xf_pkg::REG_ROW_X: row_reg[0] <= pwdata;
                aabb_xf_pkg::REG_ROW_Y: row_reg[1] <= pwdata;
                aabb_xf_pkg::REG_ROW_Z: row_reg[2] <= pwdata;
                default: ;  // unmapped address: write ignored
            endcase
        end
    end

    // Register read-back
    always_comb begin
        unique case (cfg_idx)
            aabb_xf_pkg::REG_ROW_X: prdata = row_reg[0];
            aabb_xf_pkg::REG_ROW_Y: prdata = row_reg[1];
            aabb_xf_pkg::REG_ROW_Z: prdata = row_reg[2];
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when empty or when draining
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, m_tvalid_reg;
    logic ld1, ld2, ld3, ld4;

    assign ld4      = !m_tvalid_reg || m_tready;
    assign ld3      = !v3_reg || ld4;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign s_tready = ld1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (ld1) v1_reg       <= s_tvalid;
            if (ld2) v2_reg       <= v1_reg;
            if (ld3) v3_reg       <= v2_reg;
            if (ld4) m_tvalid_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: coefficient times min and max coordinate, per axis and term
    // ------------------------------------------------------------------
    aabb_xf_pkg::prod_t plo_next [NA][NA];
    aabb_xf_pkg::prod_t phi_next [NA][NA];
    aabb_xf_pkg::prod_t plo_reg  [NA][NA];
    aabb_xf_pkg::prod_t phi_reg  [NA][NA];
    logic               bv1_reg;

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            for (int k = 0; k < NA; k++) begin
                plo_next[a][k] = aabb_xf_pkg::coef_of(row_reg[a], k)
                               * $signed(s_tdata[CW*k +: CW]);
                phi_next[a][k] = aabb_xf_pkg::coef_of(row_reg[a], k)
                               * $signed(s_tdata[CW*(NA+k) +: CW]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1) begin
            bv1_reg <= s_tuser[0];
            plo_reg <= plo_next;
            phi_reg <= phi_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: smaller and larger product of each term
    // ------------------------------------------------------------------
    aabb_xf_pkg::prod_t tmin_next [NA][NA];
    aabb_xf_pkg::prod_t tmax_next [NA][NA];
    aabb_xf_pkg::prod_t tmin_reg  [NA][NA];
    aabb_xf_pkg::prod_t tmax_reg  [NA][NA];
    logic               bv2_reg;

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            for (int k = 0; k < NA; k++) begin
                if (plo_reg[a][k] < phi_reg[a][k]) begin
                    tmin_next[a][k] = plo_reg[a][k];
                    tmax_next[a][k] = phi_reg[a][k];
                end else begin
                    tmin_next[a][k] = phi_reg[a][k];
                    tmax_next[a][k] = plo_reg[a][k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld2) begin
            bv2_reg  <= bv1_reg;
            tmin_reg <= tmin_next;
            tmax_reg <= tmax_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: full-precision sums of the three terms
    // ------------------------------------------------------------------
    aabb_xf_pkg::sum_t smin_next [NA];
    aabb_xf_pkg::sum_t smax_next [NA];
    aabb_xf_pkg::sum_t smin_reg  [NA];
    aabb_xf_pkg::sum_t smax_reg  [NA];
    logic              bv3_reg;

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            smin_next[a] = aabb_xf_pkg::sum_t'(tmin_reg[a][0])
                         + aabb_xf_pkg::sum_t'(tmin_reg[a][1])
                         + aabb_xf_pkg::sum_t'(tmin_reg[a][2]);
            smax_next[a] = aabb_xf_pkg::sum_t'(tmax_reg[a][0])
                         + aabb_xf_pkg::sum_t'(tmax_reg[a][1])
                         + aabb_xf_pkg::sum_t'(tmax_reg[a][2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ld3) begin
            bv3_reg  <= bv2_reg;
            smin_reg <= smin_next;
            smax_reg <= smax_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: floor shift, translate, saturate; zero for an empty box
    // ------------------------------------------------------------------
    aabb_xf_pkg::acc_t              amin [NA];
    aabb_xf_pkg::acc_t              amax [NA];
    aabb_xf_pkg::acc_t              tr   [NA];
    logic [aabb_xf_pkg::TDATA_W-1:0] m_tdata_next;
    logic [aabb_xf_pkg::TDATA_W-1:0] m_tdata_reg;
    logic [0:0]                      m_tuser_reg;

    always_comb begin
        m_tdata_next = '0;
        for (int a = 0; a < NA; a++) begin
            // sign-extended translation
            tr[a]   = aabb_xf_pkg::acc_t'(aabb_xf_pkg::trans_of(row_reg[a]));
            // dropping the low fraction bits floors toward minus infinity
            amin[a] = $signed({smin_reg[a][aabb_xf_pkg::SUM_W-1],
                               smin_reg[a][aabb_xf_pkg::SUM_W-1:aabb_xf_pkg::FRAC_BITS]})
                    + tr[a];
            amax[a] = $signed({smax_reg[a][aabb_xf_pkg::SUM_W-1],
                               smax_reg[a][aabb_xf_pkg::SUM_W-1:aabb_xf_pkg::FRAC_BITS]})
                    + tr[a];
            if (bv3_reg) begin
                m_tdata_next[CW*a +: CW]      = aabb_xf_pkg::sat_coord(amin[a]);
                m_tdata_next[CW*(NA+a) +: CW] = aabb_xf_pkg::sat_coord(amax[a]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld4) begin
            m_tuser_reg <= bv3_reg;
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // An empty box leaves with all coordinates zero
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("empty box result carries non-zero coordinates");

    // A produced box never has its minimum above its maximum
    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            ($signed(m_tdata[15:0])  <= $signed(m_tdata[63:48])) &&
            ($signed(m_tdata[31:16]) <= $signed(m_tdata[79:64])) &&
            ($signed(m_tdata[47:32]) <= $signed(m_tdata[95:80])))
        else $error("result box minimum exceeds maximum");

    // Input back-pressure only when every stage holds a transaction
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> v1_reg && v2_reg && v3_reg && m_tvalid_reg && !m_tready)
        else $error("s_tready low while the pipeline has room");

    // An accepted transaction reaches stage 1 on the next edge
    a_stage1_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted transaction lost at stage 1");
`endif

endmodule
